@@ hw/rtl/sarc_pkg.sv @@
// ----------------------------------------------------------------------------
// Shortest-arc rotation package
// Shared widths, thresholds, pipeline depths and interface types.
// ----------------------------------------------------------------------------
package sarc_pkg;

    localparam int FRAC_BITS  = 22;
    localparam int COMP_W     = 24;
    localparam int UNIT_BITS  = 30;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;
    localparam int SQRT_LAT   = SQRT_STEPS + 1;
    localparam int DIV_LAT    = DIV_STEPS + 1;

    localparam logic [63:0]        LEN_MIN_Q30  = 64'd858993459;
    localparam logic signed [63:0] DOT_HI_Q60   = 64'sd1152920351685342369;
    localparam logic signed [63:0] DOT_LO_Q60   = 64'sd1151768583102240129;
    localparam logic [31:0]        NORM_MIN_Q30 = 32'd1074;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [31:0]       unit_t;
    typedef logic signed [33:0]       qcomp_t;

    localparam comp_t OUT_MAX = comp_t'(24'sh7fffff);
    localparam comp_t OUT_MIN = comp_t'(24'sh800000);
    localparam comp_t IDENT_W = (FRAC_BITS >= COMP_W - 1) ? OUT_MAX :
                                comp_t'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic        valid;
        logic        ok;
        qcomp_t      qx;
        qcomp_t      qy;
        qcomp_t      qz;
        qcomp_t      qw;
        logic [63:0] n2;
    } quat_t;

    typedef struct packed {
        logic  valid;
        logic  rot_valid;
        comp_t x;
        comp_t y;
        comp_t z;
        comp_t w;
    } rot_t;

endpackage

@@ hw/rtl/sarc_isqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per stage, floor(sqrt(val)) of a 64-bit word.
// ----------------------------------------------------------------------------
module sarc_isqrt import sarc_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] val,
    output logic [31:0] root
);

    logic [63:0] v_reg [SQRT_STEPS+1];
    logic [63:0] r_reg [SQRT_STEPS+1];
    logic [63:0] v_next [SQRT_STEPS];
    logic [63:0] r_next [SQRT_STEPS];

    always_comb begin
        for (int i = 0; i < SQRT_STEPS; i++) begin
            logic [63:0] b;
            b = 64'd1 << (62 - 2 * i);
            if (v_reg[i] >= r_reg[i] + b) begin
                v_next[i] = v_reg[i] - (r_reg[i] + b);
                r_next[i] = (r_reg[i] >> 1) + b;
            end else begin
                v_next[i] = v_reg[i];
                r_next[i] = r_reg[i] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg[0] <= val;
            r_reg[0] <= '0;
            for (int i = 0; i < SQRT_STEPS; i++) begin
                v_reg[i+1] <= v_next[i];
                r_reg[i+1] <= r_next[i];
            end
        end
    end

    assign root = r_reg[SQRT_STEPS][31:0];

endmodule

@@ hw/rtl/sarc_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// 64-bit dividend by 32-bit divisor, one quotient bit per stage; the dividend
// must be below the divisor times 2^32.
// ----------------------------------------------------------------------------
module sarc_div import sarc_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic [31:0] quo
);

    logic [31:0] rem_reg [DIV_STEPS+1];
    logic [31:0] low_reg [DIV_STEPS+1];
    logic [31:0] q_reg   [DIV_STEPS+1];
    logic [31:0] d_reg   [DIV_STEPS+1];
    logic [31:0] rem_next [DIV_STEPS];
    logic        bit_next [DIV_STEPS];

    always_comb begin
        for (int i = 0; i < DIV_STEPS; i++) begin
            logic [32:0] t;
            t = {rem_reg[i], low_reg[i][31]};
            if (t >= {1'b0, d_reg[i]}) begin
                rem_next[i] = 32'(t - {1'b0, d_reg[i]});
                bit_next[i] = 1'b1;
            end else begin
                rem_next[i] = t[31:0];
                bit_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num[63:32];
            low_reg[0] <= num[31:0];
            q_reg[0]   <= '0;
            d_reg[0]   <= den;
            for (int i = 0; i < DIV_STEPS; i++) begin
                rem_reg[i+1] <= rem_next[i];
                low_reg[i+1] <= {low_reg[i][30:0], 1'b0};
                q_reg[i+1]   <= {q_reg[i][30:0], bit_next[i]};
                d_reg[i+1]   <= d_reg[i];
            end
        end
    end

    assign quo = q_reg[DIV_STEPS];

endmodule

@@ hw/rtl/sarc_norm.sv @@
// ----------------------------------------------------------------------------
// Vector normalizer
// Scales one signed vector to a Q30 unit vector; a zero vector gives zero.
// ----------------------------------------------------------------------------
module sarc_norm import sarc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  comp_t c_x,
    input  comp_t c_y,
    input  comp_t c_z,
    output logic  out_valid,
    output unit_t u_x,
    output unit_t u_y,
    output unit_t u_z
);

    typedef struct packed {
        logic [2:0]  neg;
        logic [23:0] m0;
        logic [23:0] m1;
        logic [23:0] m2;
        logic [4:0]  k;
        logic        zero;
    } nsb_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } dsb_t;

    logic [4:0]  vld_reg;
    logic [23:0] mag_reg [3];
    logic [2:0]  neg0_reg, neg1_reg, neg2_reg, neg3_reg;
    logic [23:0] mag1_reg [3];
    logic [23:0] mag2_reg [3];
    logic [23:0] mag3_reg [3];
    logic [47:0] sq_reg [3];
    logic [47:0] s_reg, s3_reg;
    logic [5:0]  cnz_reg;
    logic [3:0]  clen_reg [6];
    nsb_t        p4_reg;
    logic [63:0] x_reg;

    logic [5:0]  len_next;
    logic [5:0]  ksub;
    logic [4:0]  k_next;

    logic [SQRT_LAT-1:0] vld1_reg;
    nsb_t                sb1_reg [SQRT_LAT];
    logic [DIV_LAT-1:0]  vld2_reg;
    dsb_t                sb2_reg [DIV_LAT];

    logic [31:0] root;
    logic [63:0] num [3];
    logic [31:0] quo [3];
    nsb_t        sb1;
    dsb_t        sb2;
    unit_t       u_next [3];
    unit_t       u_reg [3];
    logic        out_vld_reg;

    always_comb begin
        len_next = '0;
        for (int j = 0; j < 6; j++) begin
            if (cnz_reg[j]) begin
                len_next = 6'(8 * j) + {2'b0, clen_reg[j]};
            end
        end
        ksub   = 6'd62 - len_next;
        k_next = ksub[5:1];
    end

    assign sb1 = sb1_reg[SQRT_LAT-1];
    assign sb2 = sb2_reg[DIV_LAT-1];

    always_comb begin
        logic [23:0] m [3];
        m[0] = sb1.m0;
        m[1] = sb1.m1;
        m[2] = sb1.m2;
        for (int i = 0; i < 3; i++) begin
            num[i] = (64'(m[i]) << (6'(UNIT_BITS) + {1'b0, sb1.k})) + 64'(root >> 1);
        end
    end

    sarc_isqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .val  (x_reg),
        .root (root)
    );

    for (genvar g = 0; g < 3; g++) begin : g_div
        sarc_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (num[g]),
            .den  (root),
            .quo  (quo[g])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [31:0] q;
            q = (quo[i] > (32'd1 << UNIT_BITS)) ? (32'd1 << UNIT_BITS) : quo[i];
            if (sb2.zero) begin
                u_next[i] = '0;
            end else if (sb2.neg[i]) begin
                u_next[i] = -$signed(q);
            end else begin
                u_next[i] = $signed(q);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            vld1_reg    <= '0;
            vld2_reg    <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[3:0], in_valid};
            vld1_reg    <= {vld1_reg[SQRT_LAT-2:0], vld_reg[4]};
            vld2_reg    <= {vld2_reg[DIV_LAT-2:0], vld1_reg[SQRT_LAT-1]};
            out_vld_reg <= vld2_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg[0] <= c_x[23] ? 24'(-c_x) : 24'(c_x);
            mag_reg[1] <= c_y[23] ? 24'(-c_y) : 24'(c_y);
            mag_reg[2] <= c_z[23] ? 24'(-c_z) : 24'(c_z);
            neg0_reg   <= {c_z[23], c_y[23], c_x[23]};
            for (int i = 0; i < 3; i++) begin
                sq_reg[i]   <= {24'b0, mag_reg[i]} * {24'b0, mag_reg[i]};
                mag1_reg[i] <= mag_reg[i];
                mag2_reg[i] <= mag1_reg[i];
                mag3_reg[i] <= mag2_reg[i];
            end
            neg1_reg <= neg0_reg;
            neg2_reg <= neg1_reg;
            neg3_reg <= neg2_reg;
            s_reg    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            s3_reg   <= s_reg;
            for (int j = 0; j < 6; j++) begin
                logic [7:0] ch;
                logic [3:0] l;
                ch = s_reg[8*j +: 8];
                l  = '0;
                for (int b = 0; b < 8; b++) begin
                    if (ch[b]) begin
                        l = 4'(b + 1);
                    end
                end
                cnz_reg[j]  <= |ch;
                clen_reg[j] <= l;
            end
            p4_reg.neg  <= neg3_reg;
            p4_reg.m0   <= mag3_reg[0];
            p4_reg.m1   <= mag3_reg[1];
            p4_reg.m2   <= mag3_reg[2];
            p4_reg.k    <= k_next;
            p4_reg.zero <= ~|cnz_reg;
            x_reg       <= {16'b0, s3_reg} << {k_next, 1'b0};
            sb1_reg[0]  <= p4_reg;
            for (int i = 1; i < SQRT_LAT; i++) begin
                sb1_reg[i] <= sb1_reg[i-1];
            end
            sb2_reg[0].neg  <= sb1.neg;
            sb2_reg[0].zero <= sb1.zero;
            for (int i = 1; i < DIV_LAT; i++) begin
                sb2_reg[i] <= sb2_reg[i-1];
            end
            for (int i = 0; i < 3; i++) begin
                u_reg[i] <= u_next[i];
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign u_x = u_reg[0];
    assign u_y = u_reg[1];
    assign u_z = u_reg[2];

endmodule

@@ hw/rtl/sarc_quat.sv @@
// ----------------------------------------------------------------------------
// Quaternion builder
// Length, dot and cross products of the unit vectors, range checks, rounding
// to Q30 and the squared quaternion norm.
// ----------------------------------------------------------------------------
module sarc_quat import sarc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  unit_t a_x,
    input  unit_t a_y,
    input  unit_t a_z,
    input  unit_t b_x,
    input  unit_t b_y,
    input  unit_t b_z,
    output quat_t q_out
);

    function automatic qcomp_t round_q30(input logic signed [63:0] v);
        logic [63:0] mag;
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
        return v[63] ? -$signed(mag[33:0]) : $signed(mag[33:0]);
    endfunction

    logic [4:0] vld_reg;

    logic signed [63:0] sqa_reg [3];
    logic signed [63:0] sqb_reg [3];
    logic signed [63:0] p_reg [3][3];

    logic               len_ok_reg;
    logic signed [63:0] d_reg, cx_reg, cy_reg, cz_reg;

    logic               ok2_reg, ok3_reg, ok4_reg;
    qcomp_t             q2_reg [4];
    qcomp_t             q3_reg [4];
    qcomp_t             q4_reg [4];
    logic [63:0]        sq_reg [4];
    logic [63:0]        n2_reg;

    unit_t              av [3];
    unit_t              bv [3];
    logic [63:0]        len_a, len_b;
    logic               ok_next;

    assign av[0] = a_x;
    assign av[1] = a_y;
    assign av[2] = a_z;
    assign bv[0] = b_x;
    assign bv[1] = b_y;
    assign bv[2] = b_z;

    assign len_a = 64'(sqa_reg[0] + sqa_reg[1] + sqa_reg[2]) >> UNIT_BITS;
    assign len_b = 64'(sqb_reg[0] + sqb_reg[1] + sqb_reg[2]) >> UNIT_BITS;
    assign ok_next = len_ok_reg && !(d_reg > DOT_HI_Q60) && !(d_reg < -DOT_LO_Q60);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sqa_reg[i] <= 64'(av[i]) * 64'(av[i]);
                sqb_reg[i] <= 64'(bv[i]) * 64'(bv[i]);
                for (int j = 0; j < 3; j++) begin
                    p_reg[i][j] <= 64'(av[i]) * 64'(bv[j]);
                end
            end
            len_ok_reg <= (len_a >= LEN_MIN_Q30) && (len_b >= LEN_MIN_Q30);
            d_reg      <= p_reg[0][0] + p_reg[1][1] + p_reg[2][2];
            cx_reg     <= p_reg[1][2] - p_reg[2][1];
            cy_reg     <= p_reg[2][0] - p_reg[0][2];
            cz_reg     <= p_reg[0][1] - p_reg[1][0];
            ok2_reg    <= ok_next;
            q2_reg[0]  <= round_q30(cx_reg);
            q2_reg[1]  <= round_q30(cy_reg);
            q2_reg[2]  <= round_q30(cz_reg);
            q2_reg[3]  <= round_q30((64'sd1 <<< 60) + d_reg);
            ok3_reg    <= ok2_reg;
            ok4_reg    <= ok3_reg;
            for (int i = 0; i < 4; i++) begin
                sq_reg[i] <= 64'(q2_reg[i]) * 64'(q2_reg[i]);
                q3_reg[i] <= q2_reg[i];
                q4_reg[i] <= q3_reg[i];
            end
            n2_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2] + sq_reg[3];
        end
    end

    assign q_out.valid = vld_reg[4];
    assign q_out.ok    = ok4_reg;
    assign q_out.qx    = q4_reg[0];
    assign q_out.qy    = q4_reg[1];
    assign q_out.qz    = q4_reg[2];
    assign q_out.qw    = q4_reg[3];
    assign q_out.n2    = n2_reg;

endmodule

@@ hw/rtl/sarc_scale.sv @@
// ----------------------------------------------------------------------------
// Quaternion scaler
// Square root of the squared norm, division of each component by the norm,
// saturation to the output width and the identity fallback.
// ----------------------------------------------------------------------------
module sarc_scale import sarc_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  quat_t q_in,
    output rot_t  rot_out
);

    typedef struct packed {
        qcomp_t qx;
        qcomp_t qy;
        qcomp_t qz;
        qcomp_t qw;
        logic   ok;
    } ssb_t;

    typedef struct packed {
        logic [3:0] neg;
        logic       ok;
    } dsb_t;

    function automatic comp_t sat_comp(input logic [31:0] r, input logic neg);
        logic signed [33:0] v;
        v = neg ? -$signed({2'b0, r}) : $signed({2'b0, r});
        if (v > 34'(OUT_MAX)) begin
            return OUT_MAX;
        end else if (v < 34'(OUT_MIN)) begin
            return OUT_MIN;
        end
        return $signed(v[COMP_W-1:0]);
    endfunction

    logic [SQRT_LAT-1:0] vld1_reg;
    ssb_t                sb1_reg [SQRT_LAT];
    logic [DIV_LAT-1:0]  vld2_reg;
    dsb_t                sb2_reg [DIV_LAT];
    ssb_t                sb1;
    dsb_t                sb2;

    logic [31:0] n;
    qcomp_t      qv [4];
    logic [63:0] num [4];
    logic [31:0] quo [4];
    rot_t        rot_reg;

    assign sb1 = sb1_reg[SQRT_LAT-1];
    assign sb2 = sb2_reg[DIV_LAT-1];
    assign qv[0] = sb1.qx;
    assign qv[1] = sb1.qy;
    assign qv[2] = sb1.qz;
    assign qv[3] = sb1.qw;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic [33:0] mag;
            mag = qv[i][33] ? 34'(-qv[i]) : 34'(qv[i]);
            num[i] = (64'(mag) << FRAC_BITS) + 64'(n >> 1);
        end
    end

    sarc_isqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .val  (q_in.n2),
        .root (n)
    );

    for (genvar g = 0; g < 4; g++) begin : g_div
        sarc_div u_div (
            .aclk (aclk),
            .en   (en),
            .num  (num[g]),
            .den  (n),
            .quo  (quo[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg      <= '0;
            vld2_reg      <= '0;
            rot_reg.valid <= 1'b0;
        end else if (en) begin
            vld1_reg      <= {vld1_reg[SQRT_LAT-2:0], q_in.valid};
            vld2_reg      <= {vld2_reg[DIV_LAT-2:0], vld1_reg[SQRT_LAT-1]};
            rot_reg.valid <= vld2_reg[DIV_LAT-1];
        end
        if (en) begin
            sb1_reg[0].qx <= q_in.qx;
            sb1_reg[0].qy <= q_in.qy;
            sb1_reg[0].qz <= q_in.qz;
            sb1_reg[0].qw <= q_in.qw;
            sb1_reg[0].ok <= q_in.ok;
            for (int i = 1; i < SQRT_LAT; i++) begin
                sb1_reg[i] <= sb1_reg[i-1];
            end
            sb2_reg[0].neg <= {qv[3][33], qv[2][33], qv[1][33], qv[0][33]};
            sb2_reg[0].ok  <= sb1.ok && (n >= NORM_MIN_Q30);
            for (int i = 1; i < DIV_LAT; i++) begin
                sb2_reg[i] <= sb2_reg[i-1];
            end
            rot_reg.rot_valid <= sb2.ok;
            if (sb2.ok) begin
                rot_reg.x <= sat_comp(quo[0], sb2.neg[0]);
                rot_reg.y <= sat_comp(quo[1], sb2.neg[1]);
                rot_reg.z <= sat_comp(quo[2], sb2.neg[2]);
                rot_reg.w <= sat_comp(quo[3], sb2.neg[3]);
            end else begin
                rot_reg.x <= '0;
                rot_reg.y <= '0;
                rot_reg.z <= '0;
                rot_reg.w <= IDENT_W;
            end
        end
    end

    assign rot_out = rot_reg;

endmodule

@@ hw/rtl/shortest_arc_rotation_core.sv @@
// ----------------------------------------------------------------------------
// Shortest-arc rotation core
// Gives the unit quaternion that turns one 3-vector onto another.
//
// A request on the slave channel carries the source and target vectors in
// signed Q2.22. Each request yields exactly one result on the master channel:
// the quaternion (x, y, z, w) in signed Q2.22 and a flag that is high when a
// rotation was produced. Degenerate inputs (zero or short vectors, vectors
// already aligned or opposite, tiny norm) give the identity with the flag low.
// The block takes one request every cycle while s_tready is high. Each result
// passes through the two 32-stage square-root pipelines and the two 32-stage
// divider pipelines in series.
// A synchronous active-low reset empties the pipeline and the output stage.
// When the receiver stalls, a two-entry output stage keeps one waiting result
// and catches the next; the pipeline then holds and s_tready falls until
// the receiver takes a result again. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module shortest_arc_rotation_core import sarc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,   // from_x, from_y, from_z, to_x, to_y, to_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,   // rot_x, rot_y, rot_z, rot_w
    output logic [0:0]   m_tuser    // rot_valid
);

    logic  pipe_en;
    logic  a_valid, b_valid;
    unit_t a_x, a_y, a_z, b_x, b_y, b_z;
    quat_t quat;
    rot_t  res;

    logic  out_valid_reg, skid_valid_reg;
    rot_t  out_data_reg, skid_data_reg;

    assign pipe_en  = ~skid_valid_reg;
    assign s_tready = pipe_en;

    sarc_norm u_norm_from (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .c_x       ($signed(s_tdata[23:0])),
        .c_y       ($signed(s_tdata[47:24])),
        .c_z       ($signed(s_tdata[71:48])),
        .out_valid (a_valid),
        .u_x       (a_x),
        .u_y       (a_y),
        .u_z       (a_z)
    );

    sarc_norm u_norm_to (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s_tvalid),
        .c_x       ($signed(s_tdata[95:72])),
        .c_y       ($signed(s_tdata[119:96])),
        .c_z       ($signed(s_tdata[143:120])),
        .out_valid (b_valid),
        .u_x       (b_x),
        .u_y       (b_y),
        .u_z       (b_z)
    );

    sarc_quat u_quat (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .in_valid (a_valid),
        .a_x      (a_x),
        .a_y      (a_y),
        .a_z      (a_z),
        .b_x      (b_x),
        .b_y      (b_y),
        .b_z      (b_z),
        .q_out    (quat)
    );

    sarc_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .q_in    (quat),
        .rot_out (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            out_valid_reg  <= skid_valid_reg || res.valid;
            skid_valid_reg <= 1'b0;
        end else if (pipe_en && res.valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end else if (pipe_en) begin
            skid_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.w, out_data_reg.z, out_data_reg.y, out_data_reg.x};
    assign m_tuser  = out_data_reg.rot_valid;

    a_skid_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a pending output");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid entry filled while the output was free");

    a_identity_form: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_data_reg.rot_valid) |->
        (out_data_reg.x == '0 && out_data_reg.y == '0 && out_data_reg.z == '0 &&
         out_data_reg.w == IDENT_W))
        else $error("fallback result is not the identity quaternion");

    a_norm_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid == b_valid)
        else $error("normalizer lanes out of step");

endmodule
